### hdl/polar_scan_point_plotter_core_assert.svh
// ---------------------------------------------------------------------------
// polar scan point plotter assertion macros
// shared concurrent assertion forms, clocked on aclk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef POLAR_SCAN_POINT_PLOTTER_CORE_ASSERT_SVH
`define POLAR_SCAN_POINT_PLOTTER_CORE_ASSERT_SVH

// same-cycle implication
`define PSPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pspp_pkg.sv
// ---------------------------------------------------------------------------
// pspp_pkg
// types, constants and the quarter sine table of the polar scan point plotter
// ---------------------------------------------------------------------------
`default_nettype none

package pspp_pkg;

    localparam int BIN_W    = 9;
    localparam int DIST_W   = 16;
    localparam int CONF_W   = 8;
    localparam int COORD_W  = 8;
    localparam int COLOUR_W = 2;
    localparam int RSEL_W   = 4;
    localparam int RANGE_W  = 14;
    localparam int SIN_W    = 31;
    localparam int AMP_W    = 23;
    localparam int PROD_W   = 54;
    localparam int FRAC_W   = 30;
    localparam int DEN_W    = 44;
    localparam int QUO_W    = 7;
    localparam int DEG_W    = 7;
    localparam int POS_W    = 9;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic CMD_ERASE = 1'b0;
    localparam logic CMD_PLOT  = 1'b1;

    localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 2'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_GREEN = 2'd1;
    localparam logic [COLOUR_W-1:0] COLOUR_RED   = 2'd2;

    localparam logic [RSEL_W-1:0] RSEL_RESET = 4'd3;
    localparam logic [RSEL_W-1:0] RSEL_MAX   = 4'd9;

    localparam logic [RANGE_W-1:0] RANGE_MM [0:9] = '{
        14'd12000, 14'd9000, 14'd6000, 14'd3000, 14'd2000,
        14'd1000, 14'd700, 14'd500, 14'd300, 14'd100
    };

    localparam logic [DIST_W-1:0] MIN_DIST    = 16'd50;
    localparam logic [CONF_W-1:0] MIN_CONF    = 8'd10;
    localparam logic [6:0]        PLOT_RADIUS = 7'd94;

    localparam logic [COORD_W-1:0] CENTRE_X = 8'd102;
    localparam logic [COORD_W-1:0] CENTRE_Y = 8'd132;

    localparam logic [POS_W-1:0] WIN_X_LO = 9'd7;
    localparam logic [POS_W-1:0] WIN_X_HI = 9'd198;
    localparam logic [POS_W-1:0] WIN_Y_LO = 9'd35;
    localparam logic [POS_W-1:0] WIN_Y_HI = 9'd228;

    localparam logic [BIN_W-1:0] DEG_QUARTER = 9'd90;
    localparam logic [BIN_W-1:0] DEG_HALF    = 9'd180;
    localparam logic [BIN_W-1:0] DEG_3Q      = 9'd270;
    localparam logic [BIN_W-1:0] DEG_FULL    = 9'd360;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TAYLOR_DIV [1:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

    typedef logic [SIN_W-1:0] sin_table_t [0:90];

    // q30 sine of 0..90 degrees, taylor series to the eleventh power
    function automatic sin_table_t build_sin_table();
        sin_table_t  tbl;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] s;
        for (int d = 0; d <= 90; d++) begin
            r    = (64'(d) * PI_Q30) / 64'(DEG_HALF);
            term = r;
            s    = r;
            for (int k = 1; k <= 5; k++) begin
                term = (((term * r) >> FRAC_W) * r) >> FRAC_W;
                term = term / TAYLOR_DIV[k];
                if ((k & 1) == 1) begin
                    s = s - term;
                end else begin
                    s = s + term;
                end
            end
            tbl[d] = s[SIN_W-1:0];
        end
        return tbl;
    endfunction

    localparam sin_table_t SIN_TABLE = build_sin_table();

    typedef struct packed {
        logic               cmd;
        logic [BIN_W-1:0]   angle_bin;
        logic [DIST_W-1:0]  reach_mm;
        logic [CONF_W-1:0]  confidence;
        logic               frame_end;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [COLOUR_W-1:0] colour_code;
        logic                last_of_run;
    } out_item_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } entry_t;

    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic               frame_end;
        logic               in_range;
        logic               drawn;
        logic [BIN_W-1:0]   bin;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

endpackage

`default_nettype wire

### hdl/pspp_calc.sv
// ---------------------------------------------------------------------------
// pspp_calc
// coordinate pipeline: angle fold, sine lookup, scaling multiply and a
// bit-per-stage floor division by the plot range
// ---------------------------------------------------------------------------
`default_nettype none

module pspp_calc #(
    parameter int ANGLE_BINS = 360
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire pspp_pkg::in_item_t            in_item,
    input  wire logic [pspp_pkg::RANGE_W-1:0]  range_mm,
    output pspp_pkg::point_t                   pt
);

    typedef struct packed {
        logic                        neg;
        logic [pspp_pkg::DEG_W-1:0]  deg;
    } fold_t;

    typedef struct packed {
        logic                        cmd;
        logic                        frame_end;
        logic                        in_range;
        logic                        keep;
        logic [pspp_pkg::BIN_W-1:0]  bin;
    } side_t;

    localparam int QW = pspp_pkg::QUO_W;

    function automatic fold_t fold_angle(input logic [pspp_pkg::BIN_W-1:0] t);
        fold_t f;
        f.neg = 1'b0;
        f.deg = '0;
        if (t <= pspp_pkg::DEG_QUARTER) begin
            f.deg = pspp_pkg::DEG_W'(t);
        end else if (t <= pspp_pkg::DEG_HALF) begin
            f.deg = pspp_pkg::DEG_W'(pspp_pkg::DEG_HALF - t);
        end else if (t <= pspp_pkg::DEG_3Q) begin
            f.neg = 1'b1;
            f.deg = pspp_pkg::DEG_W'(t - pspp_pkg::DEG_HALF);
        end else if (t < pspp_pkg::DEG_FULL) begin
            f.neg = 1'b1;
            f.deg = pspp_pkg::DEG_W'(pspp_pkg::DEG_FULL - t);
        end
        return f;
    endfunction

    // stage 1: captured item
    logic                          s1_valid_reg;
    pspp_pkg::in_item_t            s1_item_reg;
    logic [pspp_pkg::RANGE_W-1:0]  s1_range_reg;

    side_t                         s1_side;
    logic [pspp_pkg::BIN_W-1:0]    s1_theta;
    logic [pspp_pkg::BIN_W-1:0]    s1_theta_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s1_item_reg  <= in_item;
            s1_range_reg <= range_mm;
        end
    end

    always_comb begin
        s1_side.cmd       = s1_item_reg.cmd;
        s1_side.frame_end = s1_item_reg.frame_end;
        s1_side.bin       = s1_item_reg.angle_bin;
        s1_side.in_range  = s1_item_reg.angle_bin < pspp_pkg::BIN_W'(ANGLE_BINS);
        s1_side.keep      = (s1_item_reg.reach_mm >= pspp_pkg::MIN_DIST)
                          && (s1_item_reg.reach_mm <= pspp_pkg::DIST_W'(s1_range_reg))
                          && (s1_item_reg.confidence >= pspp_pkg::MIN_CONF);
        s1_theta   = (s1_item_reg.angle_bin >= pspp_pkg::DEG_HALF)
                   ? s1_item_reg.angle_bin - pspp_pkg::DEG_HALF
                   : s1_item_reg.angle_bin + pspp_pkg::DEG_HALF;
        s1_theta_c = (s1_theta >= pspp_pkg::DEG_3Q)
                   ? s1_theta - pspp_pkg::DEG_3Q
                   : s1_theta + pspp_pkg::DEG_QUARTER;
    end

    // stage 2: folded angles
    logic                          s2_valid_reg;
    side_t                         s2_side_reg;
    logic [pspp_pkg::DIST_W-1:0]   s2_dist_reg;
    logic [pspp_pkg::RANGE_W-1:0]  s2_range_reg;
    fold_t                         s2_fold_x_reg;
    fold_t                         s2_fold_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg  <= s1_valid_reg;
            s2_side_reg   <= s1_side;
            s2_dist_reg   <= s1_item_reg.reach_mm;
            s2_range_reg  <= s1_range_reg;
            s2_fold_x_reg <= fold_angle(s1_theta);
            s2_fold_y_reg <= fold_angle(s1_theta_c);
        end
    end

    // stage 3: sine magnitudes and amplitude
    logic                          s3_valid_reg;
    side_t                         s3_side_reg;
    logic [pspp_pkg::AMP_W-1:0]    s3_amp_reg;
    logic [pspp_pkg::SIN_W-1:0]    s3_sin_x_reg;
    logic [pspp_pkg::SIN_W-1:0]    s3_sin_y_reg;
    logic                          s3_neg_x_reg;
    logic                          s3_neg_y_reg;
    logic [pspp_pkg::RANGE_W-1:0]  s3_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
            s3_side_reg  <= s2_side_reg;
            s3_amp_reg   <= pspp_pkg::AMP_W'(s2_dist_reg)
                          * pspp_pkg::AMP_W'(pspp_pkg::PLOT_RADIUS);
            s3_sin_x_reg <= pspp_pkg::SIN_TABLE[s2_fold_x_reg.deg];
            s3_sin_y_reg <= pspp_pkg::SIN_TABLE[s2_fold_y_reg.deg];
            s3_neg_x_reg <= s2_fold_x_reg.neg;
            // y grows downwards, so the cosine term is subtracted
            s3_neg_y_reg <= !s2_fold_y_reg.neg;
            s3_range_reg <= s2_range_reg;
        end
    end

    // division stages, one quotient bit each
    logic                          d_valid_reg [0:QW];
    side_t                         d_side_reg  [0:QW];
    logic [pspp_pkg::PROD_W-1:0]   d_rem_x_reg [0:QW];
    logic [pspp_pkg::PROD_W-1:0]   d_rem_y_reg [0:QW];
    logic [QW-1:0]                 d_q_x_reg   [0:QW];
    logic [QW-1:0]                 d_q_y_reg   [0:QW];
    logic                          d_neg_x_reg [0:QW];
    logic                          d_neg_y_reg [0:QW];
    logic [pspp_pkg::DEN_W-1:0]    d_den_reg   [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg[0] <= 1'b0;
        end else if (en) begin
            d_valid_reg[0] <= s3_valid_reg;
            d_side_reg[0]  <= s3_side_reg;
            d_rem_x_reg[0] <= pspp_pkg::PROD_W'(s3_amp_reg) * pspp_pkg::PROD_W'(s3_sin_x_reg);
            d_rem_y_reg[0] <= pspp_pkg::PROD_W'(s3_amp_reg) * pspp_pkg::PROD_W'(s3_sin_y_reg);
            d_q_x_reg[0]   <= '0;
            d_q_y_reg[0]   <= '0;
            d_neg_x_reg[0] <= s3_neg_x_reg;
            d_neg_y_reg[0] <= s3_neg_y_reg;
            d_den_reg[0]   <= pspp_pkg::DEN_W'(s3_range_reg) << pspp_pkg::FRAC_W;
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
        localparam int B = QW - 1 - g;

        logic [pspp_pkg::PROD_W-1:0] step_den;
        logic                        take_x;
        logic                        take_y;

        assign step_den = pspp_pkg::PROD_W'(d_den_reg[g]) << B;
        assign take_x   = d_rem_x_reg[g] >= step_den;
        assign take_y   = d_rem_y_reg[g] >= step_den;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_valid_reg[g+1] <= 1'b0;
            end else if (en) begin
                d_valid_reg[g+1] <= d_valid_reg[g];
                d_side_reg[g+1]  <= d_side_reg[g];
                d_rem_x_reg[g+1] <= take_x ? d_rem_x_reg[g] - step_den : d_rem_x_reg[g];
                d_rem_y_reg[g+1] <= take_y ? d_rem_y_reg[g] - step_den : d_rem_y_reg[g];
                d_q_x_reg[g+1]   <= d_q_x_reg[g] | (QW'(take_x) << B);
                d_q_y_reg[g+1]   <= d_q_y_reg[g] | (QW'(take_y) << B);
                d_neg_x_reg[g+1] <= d_neg_x_reg[g];
                d_neg_y_reg[g+1] <= d_neg_y_reg[g];
                d_den_reg[g+1]   <= d_den_reg[g];
            end
        end
    end

    // floor towards minus infinity, offset by the centre, window test
    logic [pspp_pkg::POS_W-1:0] mag_x;
    logic [pspp_pkg::POS_W-1:0] mag_y;
    logic [pspp_pkg::POS_W-1:0] pos_x;
    logic [pspp_pkg::POS_W-1:0] pos_y;
    logic                       in_win;
    pspp_pkg::point_t           pt_next;
    pspp_pkg::point_t           pt_reg;

    always_comb begin
        mag_x = d_neg_x_reg[QW]
              ? pspp_pkg::POS_W'(d_q_x_reg[QW]) + pspp_pkg::POS_W'(|d_rem_x_reg[QW])
              : pspp_pkg::POS_W'(d_q_x_reg[QW]);
        mag_y = d_neg_y_reg[QW]
              ? pspp_pkg::POS_W'(d_q_y_reg[QW]) + pspp_pkg::POS_W'(|d_rem_y_reg[QW])
              : pspp_pkg::POS_W'(d_q_y_reg[QW]);
        pos_x = d_neg_x_reg[QW] ? pspp_pkg::POS_W'(pspp_pkg::CENTRE_X) - mag_x
                                : pspp_pkg::POS_W'(pspp_pkg::CENTRE_X) + mag_x;
        pos_y = d_neg_y_reg[QW] ? pspp_pkg::POS_W'(pspp_pkg::CENTRE_Y) - mag_y
                                : pspp_pkg::POS_W'(pspp_pkg::CENTRE_Y) + mag_y;
        in_win = (pos_x > pspp_pkg::WIN_X_LO) && (pos_x < pspp_pkg::WIN_X_HI)
              && (pos_y > pspp_pkg::WIN_Y_LO) && (pos_y < pspp_pkg::WIN_Y_HI);

        pt_next.valid     = d_valid_reg[QW];
        pt_next.cmd       = d_side_reg[QW].cmd;
        pt_next.frame_end = d_side_reg[QW].frame_end;
        pt_next.in_range  = d_side_reg[QW].in_range;
        pt_next.drawn     = (d_side_reg[QW].cmd == pspp_pkg::CMD_PLOT)
                          && d_side_reg[QW].in_range && d_side_reg[QW].keep && in_win;
        pt_next.bin       = d_side_reg[QW].bin;
        pt_next.x         = pos_x[pspp_pkg::COORD_W-1:0];
        pt_next.y         = pos_y[pspp_pkg::COORD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_reg.valid <= 1'b0;
        end else if (en) begin
            pt_reg <= pt_next;
        end
    end

    assign pt = pt_reg;

endmodule

`default_nettype wire

### hdl/pspp_store.sv
// ---------------------------------------------------------------------------
// pspp_store
// drawn position memory with read-modify-write stage, forwarding and the
// clearing pass after reset; builds the pixel items of each input item
// ---------------------------------------------------------------------------
`default_nettype none

`include "polar_scan_point_plotter_core_assert.svh"

module pspp_store #(
    parameter int ANGLE_BINS = 360
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire pspp_pkg::point_t  pt,
    output logic                   busy,
    output pspp_pkg::push_t        push
);

    localparam int AW = $clog2(ANGLE_BINS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ANGLE_BINS - 1);

    pspp_pkg::entry_t  mem [0:ANGLE_BINS-1];

    logic              clr_active_reg;
    logic [AW-1:0]     clr_addr_reg;

    logic              w_valid_reg;
    pspp_pkg::point_t  w_pt_reg;
    pspp_pkg::entry_t  rd_q_reg;
    logic              fwd_hit_reg;
    pspp_pkg::entry_t  fwd_entry_reg;

    pspp_pkg::entry_t  cur_entry;
    pspp_pkg::entry_t  wr_entry;
    logic              w_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign busy = clr_active_reg;

    always_comb begin
        wr_entry = '0;
        if (w_pt_reg.cmd == pspp_pkg::CMD_PLOT && w_pt_reg.drawn) begin
            wr_entry.valid = 1'b1;
            wr_entry.x     = w_pt_reg.x;
            wr_entry.y     = w_pt_reg.y;
        end
    end

    assign w_wr      = en && w_valid_reg && w_pt_reg.in_range;
    assign cur_entry = fwd_hit_reg ? fwd_entry_reg : rd_q_reg;

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (w_wr) begin
            mem[w_pt_reg.bin[AW-1:0]] <= wr_entry;
        end
        if (en && pt.valid && pt.in_range) begin
            rd_q_reg <= mem[pt.bin[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (en) begin
            w_valid_reg   <= pt.valid;
            w_pt_reg      <= pt;
            // write leaving this stage lands after the read of the next item
            fwd_hit_reg   <= w_valid_reg && w_pt_reg.in_range && (w_pt_reg.bin == pt.bin);
            fwd_entry_reg <= wr_entry;
        end
    end

    always_comb begin
        push = '0;
        if (w_valid_reg) begin
            if (w_pt_reg.cmd == pspp_pkg::CMD_ERASE) begin
                if (w_pt_reg.in_range && cur_entry.valid) begin
                    push.count             = 2'd1;
                    push.first.pixel_x     = cur_entry.x;
                    push.first.pixel_y     = cur_entry.y;
                    push.first.colour_code = pspp_pkg::COLOUR_BLACK;
                end
            end else begin
                if (w_pt_reg.drawn) begin
                    push.count             = 2'd1;
                    push.first.pixel_x     = w_pt_reg.x;
                    push.first.pixel_y     = w_pt_reg.y;
                    push.first.colour_code = pspp_pkg::COLOUR_GREEN;
                end
                if (w_pt_reg.frame_end) begin
                    if (w_pt_reg.drawn) begin
                        push.count              = 2'd2;
                        push.second.pixel_x     = pspp_pkg::CENTRE_X;
                        push.second.pixel_y     = pspp_pkg::CENTRE_Y;
                        push.second.colour_code = pspp_pkg::COLOUR_RED;
                    end else begin
                        push.count             = 2'd1;
                        push.first.pixel_x     = pspp_pkg::CENTRE_X;
                        push.first.pixel_y     = pspp_pkg::CENTRE_Y;
                        push.first.colour_code = pspp_pkg::COLOUR_RED;
                    end
                end
            end
            push.first.last_of_run  = (push.count == 2'd1);
            push.second.last_of_run = (push.count == 2'd2);
        end
    end

    `PSPP_ASSERT_IMPL(a_clear_idle, clr_active_reg, !w_valid_reg && !pt.valid, "item in flight during clearing pass")
    `PSPP_ASSERT_NEXT(a_clear_end, clr_active_reg && clr_addr_reg == LAST_ADDR, !clr_active_reg, "clearing pass overran")
    `PSPP_ASSERT_IMPL(a_last_mark, push.count == 2'd2, !push.first.last_of_run && push.second.last_of_run, "last_of_run not on final pixel")
    `PSPP_ASSERT_IMPL(a_erase_one, w_valid_reg && w_pt_reg.cmd == pspp_pkg::CMD_ERASE, push.count <= 2'd1, "erase gave two pixels")

endmodule

`default_nettype wire

### hdl/pspp_outq.sv
// ---------------------------------------------------------------------------
// pspp_outq
// result queue: takes up to two pixel items a cycle, hands out one, and
// holds the pipeline while fewer than two slots are free
// ---------------------------------------------------------------------------
`default_nettype none

module pspp_outq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire pspp_pkg::push_t     push,
    output logic                     en,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output pspp_pkg::out_item_t      m_item
);

    pspp_pkg::out_item_t              fifo_reg [0:pspp_pkg::OQ_DEPTH-1];
    logic [pspp_pkg::OQ_PTR_W-1:0]    rd_ptr_reg;
    logic [pspp_pkg::OQ_PTR_W-1:0]    wr_ptr_reg;
    logic [pspp_pkg::OQ_CNT_W-1:0]    count_reg;
    logic [pspp_pkg::OQ_CNT_W-1:0]    count_next;
    logic [1:0]                       push_n;
    logic                             pop;

    assign en      = count_reg <= pspp_pkg::OQ_CNT_W'(pspp_pkg::OQ_DEPTH - 2);
    assign m_valid = count_reg != '0;
    assign m_item  = fifo_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign push_n  = en ? push.count : 2'd0;

    assign count_next = count_reg + pspp_pkg::OQ_CNT_W'(push_n) - pspp_pkg::OQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= push.first;
        end
        if (push_n == 2'd2) begin
            fifo_reg[pspp_pkg::OQ_PTR_W'(wr_ptr_reg + 1'b1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_reg + pspp_pkg::OQ_PTR_W'(pop);
            wr_ptr_reg <= wr_ptr_reg + pspp_pkg::OQ_PTR_W'(push_n);
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hdl/polar_scan_point_plotter_core.sv
// first pixel item of an input item passes the calc pipeline, the store stage
// and result queue; a second (red centre) is offered once the first is taken
// one item accepted per cycle while results are taken and no item gives two
// pixel items, set by the one-item result port behind a four-entry queue
// reset starts a clearing pass of the position memory, s_ready low meanwhile
// ---------------------------------------------------------------------------
// polar_scan_point_plotter_core
// plots polar scan samples as screen pixels and erases them per angle bin
// ---------------------------------------------------------------------------
`default_nettype none

module polar_scan_point_plotter_core #(
    parameter int ANGLE_BINS = 360
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire pspp_pkg::in_item_t           s_item,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output pspp_pkg::out_item_t               m_item,
    input  wire logic                         cfg_wr_en,
    input  wire logic [pspp_pkg::RSEL_W-1:0]  cfg_wr_data
);

    logic [pspp_pkg::RSEL_W-1:0]   range_select_reg;
    logic [pspp_pkg::RSEL_W-1:0]   range_idx;
    logic [pspp_pkg::RANGE_W-1:0]  range_mm;
    logic                          en;
    logic                          busy;
    pspp_pkg::point_t              pt;
    pspp_pkg::push_t               push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_select_reg <= pspp_pkg::RSEL_RESET;
        end else if (cfg_wr_en) begin
            range_select_reg <= cfg_wr_data;
        end
    end

    // codes above the table act as the shortest range
    assign range_idx = (range_select_reg > pspp_pkg::RSEL_MAX) ? pspp_pkg::RSEL_MAX
                                                               : range_select_reg;
    assign range_mm  = pspp_pkg::RANGE_MM[range_idx];
    assign s_ready   = en && !busy;

    pspp_calc #(
        .ANGLE_BINS (ANGLE_BINS)
    ) u_calc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid && s_ready),
        .in_item  (s_item),
        .range_mm (range_mm),
        .pt       (pt)
    );

    pspp_store #(
        .ANGLE_BINS (ANGLE_BINS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .pt      (pt),
        .busy    (busy),
        .push    (push)
    );

    pspp_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .en      (en),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

### dv/tb_polar_scan_point_plotter_core.sv
// ---------------------------------------------------------------------------
// tb_polar_scan_point_plotter_core
// self-checking bench for the polar scan point plotter: a queue-fed driver
// presents scan items, a bit-exact predictor of the geometry and the position
// store builds the expected pixel items, and a monitor compares them in order
// while both sides stall in random bursts over all but the last range settings
// ---------------------------------------------------------------------------

module tb_polar_scan_point_plotter_core;

    localparam int unsigned      BINS        = 360;
    localparam int unsigned      LOW_DIST    = 50;
    localparam int unsigned      LOW_CONF    = 10;
    localparam longint           MID_X       = 102;
    localparam longint           MID_Y       = 132;
    localparam longint           RADIUS_PX   = 94;
    localparam longint unsigned  PI_FIXED    = 64'd3373259426;
    localparam int               SETTLE      = 40;
    localparam int               LIMIT       = 400000;
    localparam int               PHASE_ITEMS = 265;

    localparam int unsigned RANGE_TABLE [0:9] = '{
        12000, 9000, 6000, 3000, 2000, 1000, 700, 500, 300, 100
    };

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    pspp_pkg::in_item_t            s_item      = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    pspp_pkg::out_item_t           m_item;
    logic                          cfg_wr_en   = 1'b0;
    logic [pspp_pkg::RSEL_W-1:0]   cfg_wr_data = '0;

    pspp_pkg::in_item_t            pend_items [$];
    pspp_pkg::out_item_t           pixel_exp  [$];

    logic                          pos_valid [0:BINS-1];
    logic [7:0]                    pos_x     [0:BINS-1];
    logic [7:0]                    pos_y     [0:BINS-1];
    logic [pspp_pkg::RSEL_W-1:0]   cur_sel   = pspp_pkg::RSEL_RESET;

    bit                  idle_on   = 1'b1;
    int                  src_gap   = 0;
    int                  sink_gap  = 0;
    int                  cycles    = 0;
    int                  errors    = 0;
    int                  items_in  = 0;
    int                  n_black   = 0;
    int                  n_green   = 0;
    int                  n_red     = 0;
    int                  cfg_writes = 0;

    polar_scan_point_plotter_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned range_mm(logic [pspp_pkg::RSEL_W-1:0] sel);
        return (sel > pspp_pkg::RSEL_MAX) ? RANGE_TABLE[9] : RANGE_TABLE[sel];
    endfunction

    // q30 sine of 0..90 degrees by a truncated taylor series
    function automatic longint quarter_wave(int unsigned deg);
        longint unsigned r;
        longint unsigned term;
        longint          s;
        r    = (longint'(deg) * PI_FIXED) / 64'd180;
        term = r;
        s    = longint'(r);
        for (int unsigned k = 1; k <= 5; k++) begin
            term = (((term * r) >> 30) * r) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        return s;
    endfunction

    function automatic longint sine_q30(int unsigned t);
        t = t % 360;
        if (t <= 90) return quarter_wave(t);
        if (t <= 180) return quarter_wave(180 - t);
        if (t <= 270) return -quarter_wave(t - 180);
        return -quarter_wave(360 - t);
    endfunction

    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && (n < 0)) q = q - 1;
        return q;
    endfunction

    function automatic void predict_pixels(pspp_pkg::in_item_t it);
        pspp_pkg::out_item_t run [$];
        pspp_pkg::out_item_t px;
        int unsigned bin;
        int unsigned rng;
        int unsigned theta;
        longint      den;
        longint      amp;
        longint      xv;
        longint      yv;
        bin = 32'(it.angle_bin);
        if (it.cmd == pspp_pkg::CMD_ERASE) begin
            if (bin < BINS) begin
                if (pos_valid[bin]) begin
                    px.pixel_x     = pos_x[bin];
                    px.pixel_y     = pos_y[bin];
                    px.colour_code = pspp_pkg::COLOUR_BLACK;
                    px.last_of_run = 1'b0;
                    run.push_back(px);
                end
                pos_valid[bin] = 1'b0;
            end
        end else begin
            if (bin < BINS) begin
                rng = range_mm(cur_sel);
                pos_valid[bin] = 1'b0;
                if (it.reach_mm >= LOW_DIST && it.reach_mm <= rng
                        && it.confidence >= LOW_CONF) begin
                    theta = (bin + 180) % 360;
                    den   = longint'(rng) << 30;
                    amp   = longint'(it.reach_mm) * RADIUS_PX;
                    xv    = div_floor(MID_X * den + amp * sine_q30(theta), den);
                    yv    = div_floor(MID_Y * den - amp * sine_q30(theta + 90), den);
                    if (xv > 7 && xv < 198 && yv > 35 && yv < 228) begin
                        px.pixel_x     = xv[7:0];
                        px.pixel_y     = yv[7:0];
                        px.colour_code = pspp_pkg::COLOUR_GREEN;
                        px.last_of_run = 1'b0;
                        run.push_back(px);
                        pos_valid[bin] = 1'b1;
                        pos_x[bin]     = xv[7:0];
                        pos_y[bin]     = yv[7:0];
                    end
                end
            end
            if (it.frame_end) begin
                px.pixel_x     = 8'(MID_X);
                px.pixel_y     = 8'(MID_Y);
                px.colour_code = pspp_pkg::COLOUR_RED;
                px.last_of_run = 1'b0;
                run.push_back(px);
            end
        end
        if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
        foreach (run[i]) pixel_exp.push_back(run[i]);
    endfunction

    function automatic void queue_item(logic cmd, int unsigned bin, int unsigned reach,
                                       int unsigned conf, logic fend);
        pspp_pkg::in_item_t it;
        it.cmd         = cmd;
        it.angle_bin   = bin[pspp_pkg::BIN_W-1:0];
        it.reach_mm    = reach[pspp_pkg::DIST_W-1:0];
        it.confidence  = conf[pspp_pkg::CONF_W-1:0];
        it.frame_end   = fend;
        pend_items.push_back(it);
    endfunction

    // mostly frames of plausible plots and erases, the rest raw noise
    function automatic void queue_random_phase(int n);
        int unsigned rng;
        int unsigned reach;
        int unsigned conf;
        int unsigned pick;
        rng = range_mm(cur_sel);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                case ($urandom_range(0, 9))
                    0:       reach = $urandom_range(0, LOW_DIST + 5);
                    1:       reach = $urandom_range(rng - 5, rng + 5);
                    default: reach = $urandom_range(LOW_DIST, rng);
                endcase
                conf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, LOW_CONF + 2)
                                                   : $urandom_range(LOW_CONF, 255);
                queue_item(pspp_pkg::CMD_PLOT, $urandom_range(0, BINS - 1), reach, conf,
                           $urandom_range(0, 15) == 0);
            end else if (pick < 88) begin
                queue_item(pspp_pkg::CMD_ERASE, $urandom_range(0, BINS - 1),
                           $urandom_range(0, 65535), $urandom_range(0, 255),
                           1'($urandom_range(0, 1)));
            end else begin
                queue_item(1'($urandom_range(0, 1)), $urandom_range(0, 511),
                           $urandom_range(0, 65535), $urandom_range(0, 255),
                           1'($urandom_range(0, 1)));
            end
        end
    endfunction

    task automatic drain_wait();
        while (pend_items.size() > 0 || s_valid) @(posedge aclk);
        while (pixel_exp.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_range(logic [pspp_pkg::RSEL_W-1:0] sel);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge aclk);
        cur_sel = sel;
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    task automatic check_pixel(pspp_pkg::out_item_t got);
        pspp_pkg::out_item_t want;
        case (got.colour_code)
            pspp_pkg::COLOUR_BLACK: n_black++;
            pspp_pkg::COLOUR_GREEN: n_green++;
            default:                n_red++;
        endcase
        if (pixel_exp.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected pixel item: x=%0d y=%0d colour=%0d last=%0d",
                         got.pixel_x, got.pixel_y, got.colour_code, got.last_of_run);
        end else begin
            want = pixel_exp.pop_front();
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y
                    || got.colour_code !== want.colour_code
                    || got.last_of_run !== want.last_of_run) begin
                errors++;
                if (errors <= 10)
                    $display({"pixel mismatch: expected x=%0d y=%0d colour=%0d last=%0d,",
                              " got x=%0d y=%0d colour=%0d last=%0d"},
                             want.pixel_x, want.pixel_y, want.colour_code, want.last_of_run,
                             got.pixel_x, got.pixel_y, got.colour_code, got.last_of_run);
            end
        end
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_pixels(s_item);
                items_in++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    s_valid <= 1'b0;
                end else if (pend_items.size() > 0) begin
                    s_item  <= pend_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_pixel(m_item);
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d pixel items outstanding",
                     cycles, pixel_exp.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        foreach (pos_valid[i]) pos_valid[i] = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items at the reset range of 3000 mm
        queue_item(pspp_pkg::CMD_ERASE, 0, 0, 0, 1'b0);
        queue_item(pspp_pkg::CMD_PLOT, 0, 1000, 200, 1'b0);
        queue_item(pspp_pkg::CMD_PLOT, 90, LOW_DIST, LOW_CONF, 1'b0);
        queue_item(pspp_pkg::CMD_PLOT, 180, 3000, 255, 1'b0);
        queue_item(pspp_pkg::CMD_PLOT, 270, 3000, 255, 1'b1);
        queue_item(pspp_pkg::CMD_PLOT, 359, LOW_DIST - 1, 255, 1'b0);
        queue_item(pspp_pkg::CMD_PLOT, 45, 3001, 255, 1'b0);
        queue_item(pspp_pkg::CMD_PLOT, 135, 2000, LOW_CONF - 1, 1'b1);
        queue_item(pspp_pkg::CMD_ERASE, 0, 0, 0, 1'b0);
        queue_item(pspp_pkg::CMD_ERASE, 0, 0, 0, 1'b0);
        // replot over a stored bin, then erase at the new position
        queue_item(pspp_pkg::CMD_PLOT, 90, 2500, 100, 1'b0);
        queue_item(pspp_pkg::CMD_ERASE, 90, 0, 0, 1'b0);
        // rejected sample empties a stored bin
        queue_item(pspp_pkg::CMD_PLOT, 180, 0, 0, 1'b0);
        queue_item(pspp_pkg::CMD_ERASE, 180, 0, 0, 1'b0);
        // bins beyond the store
        queue_item(pspp_pkg::CMD_ERASE, 360, 0, 0, 1'b0);
        queue_item(pspp_pkg::CMD_ERASE, 511, 65535, 255, 1'b1);
        queue_item(pspp_pkg::CMD_PLOT, 511, 65535, 255, 1'b1);
        queue_item(pspp_pkg::CMD_PLOT, 360, 1000, 100, 1'b0);
        // frame end on erase has no effect
        queue_item(pspp_pkg::CMD_ERASE, 270, 0, 0, 1'b1);
        queue_item(pspp_pkg::CMD_PLOT, 225, 65535, 255, 1'b0);
        queue_item(pspp_pkg::CMD_PLOT, 315, 2999, LOW_CONF + 1, 1'b1);
        queue_item(pspp_pkg::CMD_ERASE, 315, 0, 0, 1'b0);
        drain_wait();

        write_range(4'd0);
        queue_random_phase(PHASE_ITEMS);
        drain_wait();

        write_range(pspp_pkg::RSEL_MAX);
        queue_random_phase(PHASE_ITEMS);
        drain_wait();

        write_range(4'd15);
        queue_random_phase(PHASE_ITEMS);
        drain_wait();

        write_range(4'd5);
        queue_random_phase(PHASE_ITEMS);
        drain_wait();

        write_range(4'($urandom_range(0, 15)));
        queue_random_phase(PHASE_ITEMS);
        drain_wait();

        // closing stretch without any idling
        write_range(pspp_pkg::RSEL_RESET);
        idle_on = 1'b0;
        queue_random_phase(PHASE_ITEMS);
        drain_wait();

        $display("run covered %0d scan items over %0d range settings in %0d cycles",
                 items_in, cfg_writes + 1, cycles);
        $display("pixel items seen: %0d black, %0d green, %0d red; %0d mismatches",
                 n_black, n_green, n_red, errors);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
